// File: rtl/core/hctp_pkg.sv
// ---------------------------------------------------------------------------
// hctp_pkg: shared types and constants of the code table parser
// Result codes, queue sizing and the request passed from parser to emitter.
// ---------------------------------------------------------------------------
`default_nettype none

package hctp_pkg;

	// longest code length accepted; longer (or zero) lengths are an error
	localparam int MAX_CODE_BITS = 32;

	// result status codes (m_tuser)
	localparam logic [1:0] ST_ENTRY  = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_TRUNC  = 2'd2;
	localparam logic [1:0] ST_BADLEN = 2'd3;

	// request queue between parser and emitter
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  symbol;
		logic [7:0]  code_len;
		logic [31:0] code_bits;
		logic        last_entry;
	} hctp_req_t;

endpackage

`default_nettype wire

// File: rtl/core/huffman_code_table_parser.sv
// ---------------------------------------------------------------------------
// huffman_code_table_parser: serialized Huffman code table parser
// Turns a byte stream holding a code table into one result per table entry.
// ---------------------------------------------------------------------------
// Input (s_*): one stream byte per request, s_tlast marks the last byte
//   available. First two bytes: entry count, low byte first. Then bits MSB
//   first: 8-bit symbol, 8-bit length, length code bits, per entry.
// Output (m_*): symbol, code length and right-aligned code in m_tdata,
//   status in m_tuser (entry / empty table / truncated / bad length), m_tlast
//   on the final entry and on every status-only result.
// Throughput: one byte per cycle while the request queue is not full; the parser
//   walks all eight bits of a byte combinationally, and a byte yields at most one result.
// Path: the byte that ends a result pushes its request into the request queue,
//   from which it moves into the output register, where the result is visible.
// Stall: s_tready drops whenever the 4-deep request queue is full, whatever
//   the next byte would produce; with the output register, five results can
//   wait while the receiver holds m_tready low before the input stops.
// Reset: arst_n clears the parser to expect a count low byte and empties
//   the queue and output register. After a table ends, padding bits in that
//   byte are dropped and the next byte starts a new table.
// ---------------------------------------------------------------------------
`default_nettype none

module huffman_code_table_parser import hctp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // end_of_stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [7:0] symbol, [15:8] code_len, [47:16] code_bits
	output logic             m_tlast,   // last_entry
	output logic [1:0]       m_tuser    // status
);

	// parser -> queue
	logic      req_valid;
	hctp_req_t req;
	logic      q_full;

	// queue -> emitter
	logic      q_valid;
	hctp_req_t q_data;
	logic      q_pop;

	// front end: byte parsing state machine
	hctp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.req_valid (req_valid),
		.req       (req)
	);

	// decoupling queue; push only happens on an accepted byte
	hctp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (req_valid && s_tvalid && s_tready),
		.push_data (req),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_data)
	);

	// back end: result formatting and output register
	hctp_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// File: rtl/core/hctp_parser.sv
// ---------------------------------------------------------------------------
// hctp_parser: byte front end
// Takes one stream byte per cycle when ready, walks its eight bits MSB first
// through the count/symbol/length/code fields and raises one request per result.
// ---------------------------------------------------------------------------
`default_nettype none

module hctp_parser import hctp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tlast,   // end_of_stream
	input  wire logic       q_full,
	output logic            req_valid,
	output hctp_req_t       req
);

	localparam logic [2:0] PH_CNT_LO = 3'd0;
	localparam logic [2:0] PH_CNT_HI = 3'd1;
	localparam logic [2:0] PH_SYM    = 3'd2;
	localparam logic [2:0] PH_LEN    = 3'd3;
	localparam logic [2:0] PH_CODE   = 3'd4;

	logic [2:0]  phase_q, phase_n;
	logic [7:0]  count_lo_q, count_lo_n;
	logic [15:0] expected_q, expected_n;
	logic [15:0] done_q, done_n;
	logic [7:0]  sym_q, sym_n;
	logic [7:0]  len_q, len_n;
	logic [2:0]  fcnt_q, fcnt_n;
	logic [7:0]  ccnt_q, ccnt_n;
	logic [31:0] acc_q, acc_n;

	logic accept;
	logic stop;
	logic bit_in;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		phase_n    = phase_q;
		count_lo_n = count_lo_q;
		expected_n = expected_q;
		done_n     = done_q;
		sym_n      = sym_q;
		len_n      = len_q;
		fcnt_n     = fcnt_q;
		ccnt_n     = ccnt_q;
		acc_n      = acc_q;
		stop       = 1'b0;
		bit_in     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;

		unique case (phase_q)
			PH_CNT_LO: begin
				count_lo_n = s_tdata;
				phase_n    = PH_CNT_HI;
				if (s_tlast) begin
					req_valid = 1'b1;
					req.kind  = ST_TRUNC;
					phase_n   = PH_CNT_LO;
				end
			end
			PH_CNT_HI: begin
				expected_n = {s_tdata, count_lo_q};
				done_n     = '0;
				sym_n      = '0;
				len_n      = '0;
				fcnt_n     = '0;
				ccnt_n     = '0;
				acc_n      = '0;
				if (expected_n == 16'd0) begin
					req_valid = 1'b1;
					req.kind  = ST_EMPTY;
					phase_n   = PH_CNT_LO;
				end else if (s_tlast) begin
					req_valid = 1'b1;
					req.kind  = ST_TRUNC;
					phase_n   = PH_CNT_LO;
				end else begin
					phase_n = PH_SYM;
				end
			end
			PH_SYM, PH_LEN, PH_CODE: begin
				// at most one entry can finish per byte (an entry is 17+ bits)
				for (int i = 7; i >= 0; i--) begin
					bit_in = s_tdata[3'(i)];
					if (!stop) begin
						if (phase_n == PH_SYM) begin
							sym_n = {sym_n[6:0], bit_in};
							if (fcnt_n == 3'd7) begin
								fcnt_n  = '0;
								phase_n = PH_LEN;
							end else begin
								fcnt_n = fcnt_n + 3'd1;
							end
						end else if (phase_n == PH_LEN) begin
							len_n = {len_n[6:0], bit_in};
							if (fcnt_n == 3'd7) begin
								fcnt_n = '0;
								if (len_n == 8'd0 || len_n > 8'(MAX_CODE_BITS)) begin
									req_valid    = 1'b1;
									req.kind     = ST_BADLEN;
									req.symbol   = sym_n;
									req.code_len = len_n;
									phase_n      = PH_CNT_LO;
									stop         = 1'b1;
								end else begin
									ccnt_n  = '0;
									acc_n   = '0;
									phase_n = PH_CODE;
								end
							end else begin
								fcnt_n = fcnt_n + 3'd1;
							end
						end else begin
							acc_n  = {acc_n[30:0], bit_in};
							ccnt_n = ccnt_n + 8'd1;
							if (ccnt_n == len_n) begin
								done_n          = done_n + 16'd1;
								req_valid       = 1'b1;
								req.kind        = ST_ENTRY;
								req.symbol      = sym_n;
								req.code_len    = len_n;
								req.code_bits   = acc_n;
								req.last_entry  = (done_n == expected_n);
								sym_n           = '0;
								len_n           = '0;
								fcnt_n          = '0;
								ccnt_n          = '0;
								acc_n           = '0;
								if (req.last_entry) begin
									phase_n = PH_CNT_LO;
									stop    = 1'b1;
								end else begin
									phase_n = PH_SYM;
								end
							end
						end
					end
				end
				// truncation replaces an entry finished in this byte
				if (!stop && s_tlast) begin
					req_valid = 1'b1;
					req       = '0;
					req.kind  = ST_TRUNC;
					phase_n   = PH_CNT_LO;
					sym_n     = '0;
					len_n     = '0;
					fcnt_n    = '0;
					ccnt_n    = '0;
					acc_n     = '0;
				end
			end
			default: begin
				phase_n = PH_CNT_LO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_CNT_LO;
			count_lo_q <= '0;
			expected_q <= '0;
			done_q     <= '0;
			sym_q      <= '0;
			len_q      <= '0;
			fcnt_q     <= '0;
			ccnt_q     <= '0;
			acc_q      <= '0;
		end else if (accept) begin
			phase_q    <= phase_n;
			count_lo_q <= count_lo_n;
			expected_q <= expected_n;
			done_q     <= done_n;
			sym_q      <= sym_n;
			len_q      <= len_n;
			fcnt_q     <= fcnt_n;
			ccnt_q     <= ccnt_n;
			acc_q      <= acc_n;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/hctp_queue.sv
// ---------------------------------------------------------------------------
// hctp_queue: request queue
// Small flop FIFO decoupling the parser from the output side.
// ---------------------------------------------------------------------------
`default_nettype none

module hctp_queue import hctp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire hctp_req_t push_data,
	output logic           full,
	input  wire logic      pop,
	output logic           pop_valid,
	output hctp_req_t      pop_data
);

	hctp_req_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push, do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// parser must never lose a request to a full queue
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push while queue full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count overflow");

	a_pop_moves_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - QCNT_W'(1)))
		else $error("pop did not retire an entry");

endmodule

`default_nettype wire

// File: rtl/core/hctp_emitter.sv
// ---------------------------------------------------------------------------
// hctp_emitter: result back end
// Pops requests, formats the result fields by status and holds them in the
// output register until the receiver takes them.
// ---------------------------------------------------------------------------
`default_nettype none

module hctp_emitter import hctp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire hctp_req_t   q_data,
	output logic             q_pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [7:0] symbol, [15:8] code_len, [47:16] code_bits
	output logic             m_tlast,   // last_entry
	output logic [1:0]       m_tuser    // status
);

	logic        valid_q;
	logic [47:0] data_q;
	logic        last_q;
	logic [1:0]  user_q;
	logic [47:0] data_n;
	logic        last_n;

	assign q_pop = q_valid && (!valid_q || m_tready);

	always_comb begin
		unique case (q_data.kind)
			ST_ENTRY: begin
				data_n = {q_data.code_bits, q_data.code_len, q_data.symbol};
				last_n = q_data.last_entry;
			end
			ST_BADLEN: begin
				data_n = {32'd0, q_data.code_len, q_data.symbol};
				last_n = 1'b1;
			end
			default: begin   // empty table, truncated stream
				data_n = '0;
				last_n = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= data_n;
			last_q <= last_n;
			user_q <= q_data.kind;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
	assign m_tuser  = user_q;

	a_nonentry_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_ENTRY) |-> m_tlast)
		else $error("non-entry result without last flag");

	a_status_only_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_EMPTY || m_tuser == ST_TRUNC)) |-> (m_tdata == '0))
		else $error("status-only result carries data");

	a_badlen_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_BADLEN) |-> (m_tdata[47:16] == 32'd0))
		else $error("bad-length result carries code bits");

endmodule

`default_nettype wire
